@@ design/dss_pkg.sv @@
package dss_pkg;

    localparam int unsigned NUMBER_W = 32;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned SEL_W    = 6;
    localparam int unsigned SEG_W    = 8;

    // x / 10 == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
    localparam logic [31:0] DIV10_MULT  = 32'hCCCC_CCCD;
    localparam int unsigned DIV10_SHIFT = 35;

    typedef logic [NUMBER_W-1:0] number_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [SEL_W-1:0]    sel_t;
    typedef logic [SEG_W-1:0]    seg_t;
    typedef logic [3:0]          bcd_t;

    // active-low segment byte, decimal point kept dark
    function automatic seg_t seg_drive_of(input bcd_t digit);
        logic [6:0] code;
        begin
            case (digit)
                4'd0:    code = 7'h3f;
                4'd1:    code = 7'h06;
                4'd2:    code = 7'h5b;
                4'd3:    code = 7'h4f;
                4'd4:    code = 7'h66;
                4'd5:    code = 7'h6d;
                4'd6:    code = 7'h7d;
                4'd7:    code = 7'h07;
                4'd8:    code = 7'h7f;
                4'd9:    code = 7'h6f;
                default: code = 7'h00;
            endcase
            seg_drive_of = ~{1'b0, code};
        end
    endfunction

endpackage

@@ design/dss_cell.sv @@
module dss_cell #(
    parameter int unsigned NUM_DIGITS = 6,
    parameter int unsigned INDEX      = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   up_valid,
    output logic                                   up_ready,
    input  dss_pkg::number_t                       up_rest,
    input  logic [NUM_DIGITS-1:0][dss_pkg::SEG_W-1:0] up_segs,
    output logic                                   dn_valid,
    input  logic                                   dn_ready,
    output dss_pkg::number_t                       dn_rest,
    output logic [NUM_DIGITS-1:0][dss_pkg::SEG_W-1:0] dn_segs
);

    logic                                      valid_reg;
    logic                                      valid_next;
    dss_pkg::number_t                          rest_reg;
    dss_pkg::number_t                          rest_next;
    logic [NUM_DIGITS-1:0][dss_pkg::SEG_W-1:0] segs_reg;
    logic [NUM_DIGITS-1:0][dss_pkg::SEG_W-1:0] segs_next;
    logic [63:0]                               product;
    dss_pkg::number_t                          quotient;
    dss_pkg::number_t                          times_ten;
    dss_pkg::number_t                          remainder;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        product   = 64'(up_rest) * 64'(dss_pkg::DIV10_MULT);
        quotient  = dss_pkg::number_t'(product >> dss_pkg::DIV10_SHIFT);
        times_ten = (quotient << 3) + (quotient << 1);
        remainder = up_rest - times_ten;
        rest_next = quotient;
        segs_next = up_segs;
        segs_next[INDEX] = dss_pkg::seg_drive_of(remainder[3:0]);
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rest_reg <= rest_next;
            segs_reg <= segs_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rest  = rest_reg;
    assign dn_segs  = segs_reg;

endmodule

@@ design/dss_serializer.sv @@
module dss_serializer #(
    parameter int unsigned NUM_DIGITS = 6
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      up_valid,
    output logic                                      up_ready,
    input  logic [NUM_DIGITS-1:0][dss_pkg::SEG_W-1:0] up_segs,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output dss_pkg::sel_t                             digit_select,
    output dss_pkg::pos_t                             digit_position,
    output dss_pkg::seg_t                             segment_drive,
    output logic                                      last
);

    logic                                      busy_reg;
    logic                                      busy_next;
    dss_pkg::pos_t                             pos_reg;
    dss_pkg::pos_t                             pos_next;
    logic [NUM_DIGITS-1:0][dss_pkg::SEG_W-1:0] segs_reg;
    logic [NUM_DIGITS-1:0][dss_pkg::SEG_W-1:0] segs_next;
    logic [7:0]                                sel_wide;
    logic                                      take;
    logic                                      load;

    assign last     = (pos_reg == '0);
    assign take     = busy_reg && out_ready;
    assign up_ready = !busy_reg || (out_ready && last);
    assign load     = up_ready && up_valid;

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        segs_next = segs_reg;
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = dss_pkg::pos_t'(NUM_DIGITS - 1);
            segs_next = up_segs;
        end
        else if (take)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                // next digit moves down into slot zero
                pos_next  = pos_reg - 3'd1;
                segs_next = segs_reg >> dss_pkg::SEG_W;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        segs_reg <= segs_next;
    end

    // positions above the select field give no select bit
    assign sel_wide       = 8'd1 << pos_reg;
    assign digit_select   = sel_wide[dss_pkg::SEL_W-1:0];
    assign digit_position = pos_reg;
    assign segment_drive  = segs_reg[0];
    assign out_valid      = busy_reg;

endmodule

@@ design/decimal_seven_segment_scan.sv @@
// Drives a multiplexed seven-segment display of NUM_DIGITS decimal digits. Each number
// accepted on the input channel (shown modulo 10^NUM_DIGITS) produces NUM_DIGITS output
// transactions, least significant digit first, starting at position NUM_DIGITS-1 and
// ending at position 0, where last is set. segment_drive is active low (bit 0 = a, bit 6
// = g, bit 7 = decimal point, always 1) and digit_select is one-hot on the position.
// The number runs through a chain of NUM_DIGITS registered divide-by-ten cells into an
// output register that shifts out one digit per cycle while out_ready is high, and loads
// the next number in the same cycle as the last digit of the one before is taken. The
// first result is offered once a number has passed every cell register into the output
// register; the chain accepts up to NUM_DIGITS further numbers while results are stalled.
module decimal_seven_segment_scan #(
    parameter int unsigned NUM_DIGITS = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           number,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [5:0]            digit_select,
    output logic [2:0]            digit_position,
    output logic [7:0]            segment_drive,
    output logic                  last
);

    logic                                      chain_valid [NUM_DIGITS+1];
    logic                                      chain_ready [NUM_DIGITS+1];
    dss_pkg::number_t                          chain_rest  [NUM_DIGITS+1];
    logic [NUM_DIGITS-1:0][dss_pkg::SEG_W-1:0] chain_segs  [NUM_DIGITS+1];

    assign chain_valid[0] = in_valid;
    assign in_ready       = chain_ready[0];
    assign chain_rest[0]  = number;
    assign chain_segs[0]  = '0;

    for (genvar k = 0; k < NUM_DIGITS; k++)
    begin : g_cell
        dss_cell #(
            .NUM_DIGITS(NUM_DIGITS),
            .INDEX     (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .up_valid(chain_valid[k]),
            .up_ready(chain_ready[k]),
            .up_rest (chain_rest[k]),
            .up_segs (chain_segs[k]),
            .dn_valid(chain_valid[k+1]),
            .dn_ready(chain_ready[k+1]),
            .dn_rest (chain_rest[k+1]),
            .dn_segs (chain_segs[k+1])
        );
    end

    dss_serializer #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_serializer (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (chain_valid[NUM_DIGITS]),
        .up_ready      (chain_ready[NUM_DIGITS]),
        .up_segs       (chain_segs[NUM_DIGITS]),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .digit_select  (digit_select),
        .digit_position(digit_position),
        .segment_drive (segment_drive),
        .last          (last)
    );

endmodule

@@ design/dss_checker.sv @@
module dss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] digit_select,
    input logic [2:0] digit_position,
    input logic [7:0] segment_drive,
    input logic       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(segment_drive)
                                    && $stable(digit_position))
        else $error("output transaction dropped or changed while stalled");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (digit_position == 3'd0)))
        else $error("last not aligned with position zero");

    a_select: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && digit_position < 3'd6 |-> $onehot(digit_select)
                                               && digit_select[digit_position])
        else $error("digit select does not match position");

    a_dp_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> segment_drive[7])
        else $error("decimal point lit");

    a_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=>
            out_valid && (digit_position == $past(digit_position) - 3'd1))
        else $error("digit run broken before last");

endmodule

bind decimal_seven_segment_scan dss_checker u_dss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .digit_select  (digit_select),
    .digit_position(digit_position),
    .segment_drive (segment_drive),
    .last          (last)
);

@@ bench/digit_scan_checker.sv @@
module digit_scan_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  dss_pkg::number_t number,
    input  logic             out_valid,
    input  logic             out_ready,
    input  dss_pkg::sel_t    digit_select,
    input  dss_pkg::pos_t    digit_position,
    input  dss_pkg::seg_t    segment_drive,
    input  logic             last,
    output int               failures,
    output int               outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS = 6;

    // plain segment codes, bit 0 = a ... bit 6 = g
    localparam logic [6:0] SEGMENT_CODE [10] = '{
        7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
    };

    typedef struct packed {
        dss_pkg::sel_t select;
        dss_pkg::pos_t position;
        dss_pkg::seg_t segments;
        logic          final_digit;
    } digit_result_t;

    digit_result_t pending_digits[$];

    // one result per display digit, least significant first, from the top position
    task automatic queue_digits(input dss_pkg::number_t value);
        dss_pkg::number_t rest;
        digit_result_t    digit;
        rest = value;
        for (int p = DIGITS - 1; p >= 0; p--)
        begin
            digit.select      = dss_pkg::sel_t'(1 << p);
            digit.position    = dss_pkg::pos_t'(p);
            digit.segments    = ~{1'b0, SEGMENT_CODE[rest % 10]};
            digit.final_digit = (p == 0);
            pending_digits.push_back(digit);
            rest = rest / 10;
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        digit_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                queue_digits(number);
            if (out_valid && out_ready)
            begin
                if (pending_digits.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual position %0d",
                             $realtime, digit_position);
                    failures++;
                end
                else
                begin
                    want = pending_digits.pop_front();
                    compare_field("digit_select", 8'(want.select), 8'(digit_select));
                    compare_field("digit_position", 8'(want.position), 8'(digit_position));
                    compare_field("segment_drive", want.segments, segment_drive);
                    compare_field("last", 8'(want.final_digit), 8'(last));
                end
            end
            outstanding = pending_digits.size();
        end
    end

endmodule

@@ bench/testbench.sv @@
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_COUNT = 102;
    localparam int DIRECTED_COUNT = 18;

    localparam dss_pkg::number_t DIRECTED_NUMBERS [DIRECTED_COUNT] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd100000, 32'd123456, 32'd654321, 32'd789012,
        32'd888888, 32'd999999, 32'd1000000, 32'd1000001, 32'd4294000000, 32'd4293999999,
        32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
    };

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    dss_pkg::number_t number = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    dss_pkg::sel_t    digit_select;
    dss_pkg::pos_t    digit_position;
    dss_pkg::seg_t    segment_drive;
    logic             last;
    int               failures;
    int               outstanding;
    bit               directed_done = 1'b0;

    always #5 clk = ~clk;

    decimal_seven_segment_scan i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .number         (number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digit_select   (digit_select),
        .digit_position (digit_position),
        .segment_drive  (segment_drive),
        .last           (last)
    );

    digit_scan_checker i_digit_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .number         (number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digit_select   (digit_select),
        .digit_position (digit_position),
        .segment_drive  (segment_drive),
        .last           (last),
        .failures       (failures),
        .outstanding    (outstanding)
    );

    // offer one number, optionally after random idle cycles, and wait until it is accepted
    task automatic send_number(input dss_pkg::number_t value, input bit allow_gap);
        while (allow_gap && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        number   <= value;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    initial
    begin
        int unsigned      pick;
        dss_pkg::number_t value;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_number(DIRECTED_NUMBERS[i], 1'b1);
        directed_done = 1'b1;

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            if (i == 60)
            begin
                // let the display drain completely before going on
                in_valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(99);
            if (pick < 40)
                value = $urandom();
            else if (pick < 70)
                value = $urandom_range(999999);
            else if (pick < 85)
                value = $urandom_range(4294) * 1000000 + $urandom_range(9);
            else
                value = $urandom_range(4293) * 1000000 + 999999 - $urandom_range(9);
            // back-to-back stretch in the middle of the random part
            send_number(value, (i < 70 || i >= 95));
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        while (!rst_n)
            @(posedge clk);
        while (!directed_done)
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= 34);
        end
        // long hold-off so the divider chain fills and the input backs up
        for (int held = 0; held < 80; held++)
        begin
            @(posedge clk);
            out_ready <= 1'b0;
        end
        for (int open = 0; open < 150; open++)
        begin
            @(posedge clk);
            out_ready <= 1'b1;
        end
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= 34);
        end
    end

    initial
    begin
        #1ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
